### hw/rtl/dgcd_pkg.sv
// dwell gesture click detector: shared types, constants and register indexes
// no dependencies; used by dgcd_step and dwell_gesture_click_detector
`timescale 1ns / 1ps

package dgcd_pkg;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned ThreshW    = 12;
  localparam int unsigned IdleW      = 8;
  localparam int unsigned CenterW    = 11;
  localparam int unsigned CountW     = 9;
  localparam int unsigned ClickW     = 13;
  localparam int unsigned CfgDataW   = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned InDataW    = 64;
  localparam int unsigned OutDataW   = 40;

  // 20 px in Q12.4
  localparam logic signed [CoordW:0] GestureDist = 17'sd320;
  localparam logic [CountW-1:0]      CountMax    = 9'd511;

  localparam logic [ThreshW-1:0] ThreshRst  = 12'd80;
  localparam logic [IdleW-1:0]   IdleRst    = 8'd10;
  localparam logic [CenterW-1:0] CenterXRst = 11'd960;
  localparam logic [CenterW-1:0] CenterYRst = 11'd540;

  typedef enum logic [CfgIdxW-1:0] {
    RegStillThreshold = 2'd0,
    RegIdleLimit      = 2'd1,
    RegCenterX        = 2'd2,
    RegCenterY        = 2'd3
  } dgcd_reg_e;

  typedef struct packed {
    logic [ThreshW-1:0] still_threshold;
    logic [IdleW-1:0]   idle_limit;
    logic [CenterW-1:0] center_x;
    logic [CenterW-1:0] center_y;
  } dgcd_cfg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] prev_x;
    logic signed [CoordW-1:0] prev_y;
  } dgcd_item_t;

  typedef struct packed {
    logic                     armed;
    logic [CountW-1:0]        count;
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
  } dgcd_state_t;

  typedef struct packed {
    logic                     armed;
    logic                     arm_event;
    logic                     left_click;
    logic                     right_click;
    logic                     double_click;
    logic                     press_left;
    logic                     timeout_event;
    logic signed [ClickW-1:0] click_x;
    logic signed [ClickW-1:0] click_y;
  } dgcd_result_t;

endpackage

### hw/rtl/dwell_gesture_click_detector.sv
// dwell gesture click detector, top level: request registers, state and config
// depends on dgcd_pkg and dgcd_step
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata[63:0]: pos_x, pos_y, prev_x, prev_y
// m_axis    out  m_axis_tvalid/tready      tdata[39:0]: flags, click_x, click_y, pad
// cfg       in   cfg_we_i                  cfg_idx_i, cfg_wdata_i (no read-back)
//
// one request per cycle sustained while the output is not stalled; an accepted request
// goes to the input register, then its result to the result register; the input register feeds
// the frame logic, the result register holds the answer; state updates when a request moves
// from input register to result register; a stalled result holds; one more request waits in
// the input register meanwhile; reset clears state, config to defaults, both registers empty
`timescale 1ns / 1ps

module dwell_gesture_click_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pos_x[15:0], pos_y[31:16], prev_x[47:32], prev_y[63:48]
  input  logic [dgcd_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // armed[0], arm_event[1], left_click[2], right_click[3], double_click[4],
  // press_left[5], timeout_event[6], click_x[19:7], click_y[32:20], zero[39:33]
  output logic [dgcd_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [dgcd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dgcd_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  dgcd_pkg::dgcd_cfg_t    cfg_q;
  dgcd_pkg::dgcd_item_t   item_q;
  dgcd_pkg::dgcd_state_t  state_q, state_d;
  dgcd_pkg::dgcd_result_t res_q, res_d;
  logic                   in_valid_q, out_valid_q;
  logic                   advance, accept;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  dgcd_step u_step (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.still_threshold <= dgcd_pkg::ThreshRst;
      cfg_q.idle_limit      <= dgcd_pkg::IdleRst;
      cfg_q.center_x        <= dgcd_pkg::CenterXRst;
      cfg_q.center_y        <= dgcd_pkg::CenterYRst;
    end else if (cfg_we_i) begin
      unique case (dgcd_pkg::dgcd_reg_e'(cfg_idx_i))
        dgcd_pkg::RegStillThreshold: cfg_q.still_threshold <= cfg_wdata_i;
        dgcd_pkg::RegIdleLimit:      cfg_q.idle_limit <= cfg_wdata_i[dgcd_pkg::IdleW-1:0];
        dgcd_pkg::RegCenterX:        cfg_q.center_x <= cfg_wdata_i[dgcd_pkg::CenterW-1:0];
        dgcd_pkg::RegCenterY:        cfg_q.center_y <= cfg_wdata_i[dgcd_pkg::CenterW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.pos_x  <= s_axis_tdata[15:0];
      item_q.pos_y  <= s_axis_tdata[31:16];
      item_q.prev_x <= s_axis_tdata[47:32];
      item_q.prev_y <= s_axis_tdata[63:48];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tdata = {7'b0, res_q.click_y, res_q.click_x, res_q.timeout_event,
                         res_q.press_left, res_q.double_click, res_q.right_click,
                         res_q.left_click, res_q.arm_event, res_q.armed};

  // an arming frame reports armed and no gesture
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.arm_event) |-> (res_q.armed && !res_q.left_click &&
      !res_q.right_click && !res_q.double_click && !res_q.press_left))
    else $error("arm event with gesture or not armed");

  // click coordinates are zero unless a click fired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !(res_q.left_click || res_q.right_click ||
      res_q.double_click || res_q.press_left))
      |-> (res_q.click_x == '0 && res_q.click_y == '0))
    else $error("click coordinates without click");

  // any click or timeout leaves the detector disarmed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_q.timeout_event || res_q.left_click || res_q.right_click ||
      res_q.double_click || res_q.press_left)) |-> !res_q.armed)
    else $error("still armed after click or timeout");

  // input back-pressure only when both registers are full and output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without cause");

endmodule

### hw/rtl/dgcd_step.sv
// dwell gesture click detector: next state and result for one frame
// depends on dgcd_pkg
`timescale 1ns / 1ps

module dgcd_step (
  input  dgcd_pkg::dgcd_cfg_t    cfg_i,
  input  dgcd_pkg::dgcd_item_t   item_i,
  input  dgcd_pkg::dgcd_state_t  state_i,
  output dgcd_pkg::dgcd_state_t  state_o,
  output dgcd_pkg::dgcd_result_t result_o
);

  logic signed [dgcd_pkg::CoordW:0]   diff_x, diff_y;
  logic [dgcd_pkg::CoordW-1:0]        abs_x, abs_y;
  logic [dgcd_pkg::CoordW:0]          step_l1;
  logic                               still;
  logic signed [dgcd_pkg::CoordW:0]   dx, dy;
  logic                               lft, rgt, dbl, prs, any_click;
  logic [dgcd_pkg::CountW-1:0]        cnt_inc;
  logic signed [dgcd_pkg::CoordW:0]   ox_adj, oy_adj;
  logic signed [dgcd_pkg::ClickW-1:0] ox_px, oy_px;

  always_comb begin
    diff_x  = {item_i.pos_x[15], item_i.pos_x} - {item_i.prev_x[15], item_i.prev_x};
    diff_y  = {item_i.pos_y[15], item_i.pos_y} - {item_i.prev_y[15], item_i.prev_y};
    abs_x   = diff_x[16] ? dgcd_pkg::CoordW'(-diff_x) : diff_x[15:0];
    abs_y   = diff_y[16] ? dgcd_pkg::CoordW'(-diff_y) : diff_y[15:0];
    step_l1 = {1'b0, abs_x} + {1'b0, abs_y};
    still   = step_l1 < {5'b0, cfg_i.still_threshold};

    dx  = {item_i.pos_x[15], item_i.pos_x} - {state_i.origin_x[15], state_i.origin_x};
    dy  = {item_i.pos_y[15], item_i.pos_y} - {state_i.origin_y[15], state_i.origin_y};
    lft = state_i.armed && (dx < -dgcd_pkg::GestureDist);
    rgt = state_i.armed && (dx > dgcd_pkg::GestureDist);
    dbl = state_i.armed && (dy < -dgcd_pkg::GestureDist);
    prs = state_i.armed && (dy > dgcd_pkg::GestureDist);
    any_click = lft | rgt | dbl | prs;

    cnt_inc = (state_i.count == dgcd_pkg::CountMax) ? state_i.count
                                                    : state_i.count + 9'd1;

    // truncate toward zero to whole pixels
    ox_adj = {state_i.origin_x[15], state_i.origin_x}
             + (state_i.origin_x[15] ? 17'sd15 : 17'sd0);
    oy_adj = {state_i.origin_y[15], state_i.origin_y}
             + (state_i.origin_y[15] ? 17'sd15 : 17'sd0);
    ox_px  = ox_adj[16:4];
    oy_px  = oy_adj[16:4];

    state_o  = state_i;
    result_o = '0;

    if (state_i.armed) begin
      if (any_click) begin
        state_o.armed    = 1'b0;
        result_o.click_x = ox_px + $signed({2'b00, cfg_i.center_x});
        result_o.click_y = oy_px + $signed({2'b00, cfg_i.center_y});
      end
      if (still) begin
        state_o.count = cnt_inc;
        if (cnt_inc > {cfg_i.idle_limit, 1'b0}) begin
          result_o.timeout_event = 1'b1;
          state_o.armed          = 1'b0;
          state_o.count          = '0;
        end
      end
    end else if (still) begin
      state_o.count = cnt_inc;
      if (cnt_inc > {1'b0, cfg_i.idle_limit}) begin
        result_o.arm_event = 1'b1;
        state_o.armed      = 1'b1;
        state_o.count      = '0;
        state_o.origin_x   = item_i.pos_x;
        state_o.origin_y   = item_i.pos_y;
      end
    end else begin
      state_o.count = '0;
    end

    result_o.armed        = state_o.armed;
    result_o.left_click   = lft;
    result_o.right_click  = rgt;
    result_o.double_click = dbl;
    result_o.press_left   = prs;
  end

endmodule

### tb/sv/tb_dwell_gesture_click_detector.sv
// testbench for dwell_gesture_click_detector: directed frames, a long dwell and random
// dwell / gesture streams, each result checked field by field against an in-bench model
// depends on dgcd_pkg and the detector rtl
`timescale 1ns / 1ps

module tb_dwell_gesture_click_detector;

  localparam int GestureQ4     = 320;
  localparam int DwellCountMax = 511;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          s_valid   = 1'b0;
  logic                          s_ready;
  logic [dgcd_pkg::InDataW-1:0]  s_data    = '0;
  logic                          m_valid;
  logic                          m_ready   = 1'b0;
  logic [dgcd_pkg::OutDataW-1:0] m_data;
  logic                          cfg_we    = 1'b0;
  logic [dgcd_pkg::CfgIdxW-1:0]  cfg_idx   = '0;
  logic [dgcd_pkg::CfgDataW-1:0] cfg_wdata = '0;

  dwell_gesture_click_detector i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  // model of the detector: configuration and state
  int still_thr = dgcd_pkg::ThreshRst;
  int idle_lim  = dgcd_pkg::IdleRst;
  int cen_x     = dgcd_pkg::CenterXRst;
  int cen_y     = dgcd_pkg::CenterYRst;
  bit gest_armed;
  int dwell_cnt;
  int org_x;
  int org_y;

  dgcd_pkg::dgcd_result_t frame_results_q[$];
  int unsigned  err_cnt;
  int unsigned  results_seen;
  int unsigned  frames_sent;
  bit           steady_src;
  bit           steady_sink;

  initial forever #2 clk = ~clk;

  initial begin
    #1_000_000;
    $display("tb_dwell_gesture_click_detector: FAIL");
    $finish;
  end

  function automatic int abs_i(input int v);
    return v < 0 ? -v : v;
  endfunction

  // whole pixels, truncated toward zero
  function automatic int whole_px(input int q);
    return q < 0 ? -((-q) >>> 4) : q >>> 4;
  endfunction

  function automatic int clamp16(input int v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic int rnd_pm(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic int rand_full();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int rand_pos();
    if ($urandom_range(0, 99) < 80) return rnd_pm(8000);
    return rand_full();
  endfunction

  function automatic dgcd_pkg::dgcd_result_t predict_frame(input int px, input int py,
                                                           input int qx, input int qy);
    dgcd_pkg::dgcd_result_t r;
    bit           still;
    int           dx;
    int           dy;
    r     = '0;
    still = (abs_i(px - qx) + abs_i(py - qy)) < still_thr;
    if (gest_armed) begin
      dx = px - org_x;
      dy = py - org_y;
      if (dx < -GestureQ4) begin
        r.left_click = 1'b1;
        gest_armed   = 1'b0;
      end
      if (dx > GestureQ4) begin
        r.right_click = 1'b1;
        gest_armed    = 1'b0;
      end
      if (dy < -GestureQ4) begin
        r.double_click = 1'b1;
        gest_armed     = 1'b0;
      end
      if (dy > GestureQ4) begin
        r.press_left = 1'b1;
        gest_armed   = 1'b0;
      end
      if (r.left_click || r.right_click || r.double_click || r.press_left) begin
        r.click_x = dgcd_pkg::ClickW'(whole_px(org_x) + cen_x);
        r.click_y = dgcd_pkg::ClickW'(whole_px(org_y) + cen_y);
      end
      if (still) begin
        if (dwell_cnt < DwellCountMax) dwell_cnt++;
        if (dwell_cnt > 2 * idle_lim) begin
          r.timeout_event = 1'b1;
          gest_armed      = 1'b0;
          dwell_cnt       = 0;
        end
      end
    end else if (still) begin
      if (dwell_cnt < DwellCountMax) dwell_cnt++;
      if (dwell_cnt > idle_lim) begin
        r.arm_event = 1'b1;
        gest_armed  = 1'b1;
        dwell_cnt   = 0;
        org_x       = px;
        org_y       = py;
      end
    end else begin
      dwell_cnt = 0;
    end
    r.armed = gest_armed;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_cnt < 40) $display("mismatch at result %0d: %s", results_seen, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [dgcd_pkg::ClickW-1:0] got,
                             input logic [dgcd_pkg::ClickW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) m_ready <= steady_sink || ($urandom_range(0, 99) >= 12);

  always @(posedge clk) begin : result_check
    dgcd_pkg::dgcd_result_t want;
    if (rst_n && m_valid && m_ready) begin
      results_seen++;
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with no pending request");
      end else begin
        want = frame_results_q.pop_front();
        check_field("armed", m_data[0], want.armed);
        check_field("arm_event", m_data[1], want.arm_event);
        check_field("left_click", m_data[2], want.left_click);
        check_field("right_click", m_data[3], want.right_click);
        check_field("double_click", m_data[4], want.double_click);
        check_field("press_left", m_data[5], want.press_left);
        check_field("timeout_event", m_data[6], want.timeout_event);
        check_field("click_x", m_data[19:7], want.click_x);
        check_field("click_y", m_data[32:20], want.click_y);
        check_field("pad", m_data[39:33], '0);
      end
    end
  end

  task automatic send_frame(input int px, input int py, input int qx, input int qy);
    if (!steady_src && $urandom_range(0, 99) < 12) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {16'(qy), 16'(qx), 16'(py), 16'(px)};
    do @(posedge clk); while (!s_ready);
    frame_results_q.push_back(predict_frame(px, py, qx, qy));
    frames_sent++;
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input dgcd_pkg::dgcd_reg_e idx,
                           input logic [dgcd_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      dgcd_pkg::RegStillThreshold: still_thr = int'(val);
      dgcd_pkg::RegIdleLimit:      idle_lim  = int'(val[dgcd_pkg::IdleW-1:0]);
      dgcd_pkg::RegCenterX:        cen_x     = int'(val[dgcd_pkg::CenterW-1:0]);
      dgcd_pkg::RegCenterY:        cen_y     = int'(val[dgcd_pkg::CenterW-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [dgcd_pkg::CfgDataW-1:0] thr,
                                input logic [dgcd_pkg::CfgDataW-1:0] idle,
                                input logic [dgcd_pkg::CfgDataW-1:0] cx,
                                input logic [dgcd_pkg::CfgDataW-1:0] cy);
    wait_drained();
    write_reg(dgcd_pkg::RegStillThreshold, thr);
    write_reg(dgcd_pkg::RegIdleLimit, idle);
    write_reg(dgcd_pkg::RegCenterX, cx);
    write_reg(dgcd_pkg::RegCenterY, cy);
  endtask

  // frame whose step stays below the threshold, around (x, y)
  task automatic send_jitter(input int x, input int y, input int cap);
    int b;
    int dx;
    int dy;
    b  = still_thr > 0 ? int'($urandom_range(0, (still_thr - 1 < cap) ? still_thr - 1 : cap)) : 0;
    dx = $urandom_range(0, b);
    dy = b - dx;
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    send_frame(clamp16(x + dx), clamp16(y + dy), clamp16(x), clamp16(y));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1)) send_frame(rand_full(), rand_full(), rand_full(), rand_full());
      else send_jitter(rand_pos(), rand_pos(), 4095);
    end
  endtask

  // dwell until armed, wander near the origin, then a gesture or a timeout
  task automatic dwell_sequence(input bit to_timeout);
    int ax;
    int ay;
    int mag;
    int xdir;
    int ydir;
    int px;
    int py;
    ax = rand_pos();
    ay = rand_pos();
    while (!gest_armed) send_jitter(ax, ay, 4095);
    repeat ($urandom_range(0, idle_lim)) begin
      if (!gest_armed) break;
      px = clamp16(org_x + rnd_pm(300));
      py = clamp16(org_y + rnd_pm(300));
      send_frame(px, py, clamp16(px + rnd_pm(60)), clamp16(py + rnd_pm(60)));
    end
    if (!to_timeout && gest_armed) begin
      mag  = $urandom_range(0, 2) == 0 ? GestureQ4 + int'($urandom_range(0, 2))
                                       : int'($urandom_range(GestureQ4 + 1, 4000));
      xdir = int'($urandom_range(0, 2)) - 1;
      ydir = int'($urandom_range(0, 2)) - 1;
      if (xdir == 0 && ydir == 0) xdir = $urandom_range(0, 1) ? 1 : -1;
      px = clamp16(org_x + (xdir != 0 ? xdir * mag : rnd_pm(300)));
      py = clamp16(org_y + (ydir != 0 ? ydir * int'($urandom_range(GestureQ4, 4000))
                                      : rnd_pm(300)));
      if ($urandom_range(0, 3) == 0) send_frame(px, py, px, py);
      else send_frame(px, py, clamp16(px + rnd_pm(2000)), clamp16(py + rnd_pm(2000)));
    end
    while (gest_armed) send_jitter(org_x, org_y, 300);
  endtask

  task automatic run_sequences(input int unsigned n);
    int unsigned first;
    first = frames_sent;
    while (frames_sent - first < n) begin
      if (still_thr > 0 && $urandom_range(0, 99) < 75) dwell_sequence($urandom_range(0, 3) == 0);
      else noise_burst();
    end
  endtask

  task automatic test_field_extremes();
    send_frame(32767, -32768, -32768, 32767);
    send_frame(-32768, 32767, 32767, -32768);
    send_frame(-1, -1, -1, -1);
    send_frame(0, 0, 0, 0);
    send_frame(32767, 32767, 32767, 32767);
    send_frame(-32768, -32768, -32768, -32768);
  endtask

  // idle limit zero: one still frame arms, the first still armed frame times out
  task automatic test_gestures_directed();
    apply_settings(dgcd_pkg::ThreshRst, 0, dgcd_pkg::CenterXRst, dgcd_pkg::CenterYRst);
    send_frame(-1000, -37, -1000, -37);
    send_frame(-1321, -37, 0, 0);
    send_frame(500, 333, 500, 333);
    send_frame(821, 333, 0, 0);
    send_frame(-8, 7, -8, 7);
    send_frame(-8, -314, 3000, 3000);
    send_frame(32767, -32768, 32767, -32768);
    send_frame(32767, -32447, 0, 0);
    // exactly 20 px is no gesture, just past it on two axes gives two clicks
    send_frame(100, 100, 100, 100);
    send_frame(-220, 420, 0, 0);
    send_frame(-221, 421, 0, 0);
    // far but still: clicks and timeout together
    send_frame(0, 0, 0, 0);
    send_frame(400, -400, 400, -400);
    send_frame(16, 16, 16, 16);
    send_frame(16, 16, 60, 16);
    // step equal to the threshold is a move
    send_frame(0, 0, 80, 0);
    send_frame(0, 0, 79, 0);
    send_frame(0, 0, 0, 0);
  endtask

  // widest limits: count runs up to its ceiling before the timeout
  task automatic test_long_dwell();
    apply_settings(4095, 255, 2047, 2047);
    dwell_sequence(1'b1);
  endtask

  task automatic test_random_gestures();
    logic [dgcd_pkg::CfgDataW-1:0] thr;
    logic [dgcd_pkg::CfgDataW-1:0] idle;
    logic [dgcd_pkg::CfgDataW-1:0] cx;
    logic [dgcd_pkg::CfgDataW-1:0] cy;
    apply_settings(dgcd_pkg::ThreshRst, dgcd_pkg::IdleRst, dgcd_pkg::CenterXRst,
                   dgcd_pkg::CenterYRst);
    steady_src  = 1'b1;
    steady_sink = 1'b1;
    run_sequences(100);
    steady_src  = 1'b0;
    steady_sink = 1'b0;
    run_sequences(30);
    wait_drained();
    run_sequences(30);
    // nothing is ever still
    apply_settings(0, dgcd_pkg::IdleRst, 1, 1);
    repeat (15) noise_burst();
    apply_settings(1, 1, 1024, 2047);
    run_sequences(50);
    repeat (4) begin
      thr  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 4095) : $urandom_range(16, 400);
      idle = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 12);
      idle = idle | (dgcd_pkg::CfgDataW'($urandom_range(0, 15)) << dgcd_pkg::IdleW);
      cx   = dgcd_pkg::CfgDataW'($urandom_range(1, 2047))
             | (dgcd_pkg::CfgDataW'($urandom_range(0, 1)) << 11);
      cy   = dgcd_pkg::CfgDataW'($urandom_range(1, 2047))
             | (dgcd_pkg::CfgDataW'($urandom_range(0, 1)) << 11);
      apply_settings(thr, idle, cx, cy);
      run_sequences(35);
    end
  endtask

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_gestures_directed();
    test_long_dwell();
    test_random_gestures();
    s_valid <= 1'b0;
    guard = 0;
    while (frame_results_q.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (frame_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_results_q.size()));
    if (err_cnt == 0) begin
      $display("tb_dwell_gesture_click_detector: PASS");
    end else begin
      $display("tb_dwell_gesture_click_detector: FAIL");
    end
    $finish;
  end

endmodule

### dwell_gesture_click_detector.f
hw/rtl/dgcd_pkg.sv
hw/rtl/dgcd_step.sv
hw/rtl/dwell_gesture_click_detector.sv
tb/sv/tb_dwell_gesture_click_detector.sv
